// ===== sv/cfpp_pkg.sv =====
// ---------------------------------------------------------------------------
// cfpp_pkg
// Shared constants, widths and the byte-wide CRC-16 update for the
// length-prefixed frame parser.
// ---------------------------------------------------------------------------
package cfpp_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 11;
    localparam int LEN_W    = 10;
    localparam int STATUS_W = 2;
    localparam int CRC_W    = 16;

    // framing constants
    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hAA;
    localparam logic [LEN_W-1:0]  LIMIT_RESET = 10'd1017;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [POS_W-1:0]  TRAILER_LEN = 11'd2;
    // largest remaining count: longest payload plus two trailer bytes
    localparam logic [POS_W-1:0]  REMAIN_MAX  = 11'd1025;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd3;

    // crc-16 update by one byte, msb first, eight narrow shift steps
    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc[CRC_W-1]) begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/cfpp_in_reg.sv =====
// ---------------------------------------------------------------------------
// cfpp_in_reg
// Input register: holds one received byte until the parser core takes it.
// ---------------------------------------------------------------------------
module cfpp_in_reg
    import cfpp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              hold_valid,
    output logic [BYTE_W-1:0] hold_byte,
    input  logic              hold_take
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // room when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || hold_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !hold_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

// ===== sv/cfpp_core.sv =====
// ---------------------------------------------------------------------------
// cfpp_core
// Frame state, running crc and the result register. Unless the result
// stalls, one byte per cycle is parsed from input to result register.
// ---------------------------------------------------------------------------
module cfpp_core
    import cfpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                hold_valid,
    input  logic [BYTE_W-1:0]   hold_byte,
    output logic                hold_take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_frame_byte,
    output logic [POS_W-1:0]    m_byte_position,
    output logic                m_frame_end,
    output logic [STATUS_W-1:0] m_frame_status
);

    // phase codes
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_FLAG_L = 2'd1;
    localparam logic [1:0] PH_FLAG_H = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [LEN_W-1:0]    limit_reg;
    logic [1:0]          phase_reg, phase_next;
    logic [POS_W-1:0]    remain_reg, remain_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [BYTE_W-1:0]   trail_reg, trail_next;
    logic [POS_W-1:0]    fpos_reg, fpos_next;
    logic [1:0]          lenlo_reg, lenlo_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [POS_W-1:0]    out_pos_reg, res_pos;
    logic                out_end_reg, res_end;
    logic [STATUS_W-1:0] out_status_reg, res_status;
    logic                res_valid;

    logic [CRC_W-1:0]    crc_upd;
    logic [LEN_W-1:0]    flag_len;
    logic [POS_W-1:0]    fpos_inc;

    // take a byte whenever the result slot is free or draining
    assign hold_take = hold_valid && (!out_valid_reg || m_ready);

    assign crc_upd  = crc_feed(crc_reg, hold_byte);
    assign flag_len = {hold_byte, lenlo_reg};
    assign fpos_inc = fpos_reg + 1'b1;

    // per-byte frame parsing
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        crc_next    = crc_reg;
        trail_next  = trail_reg;
        fpos_next   = fpos_reg;
        lenlo_next  = lenlo_reg;
        res_valid   = 1'b1;
        res_pos     = fpos_reg;
        res_end     = 1'b0;
        res_status  = STATUS_BUSY;
        unique case (phase_reg)
            PH_HUNT: begin
                if (hold_byte == SYNC_BYTE) begin
                    crc_next   = crc_feed('0, hold_byte);
                    res_pos    = '0;
                    fpos_next  = POS_W'(1);
                    phase_next = PH_FLAG_L;
                end else begin
                    res_valid = 1'b0;
                end
            end
            PH_FLAG_L: begin
                lenlo_next = hold_byte[7:6];
                crc_next   = crc_upd;
                fpos_next  = fpos_inc;
                phase_next = PH_FLAG_H;
            end
            PH_FLAG_H: begin
                if (flag_len > limit_reg) begin
                    res_end    = 1'b1;
                    res_status = STATUS_LONG;
                    phase_next = PH_HUNT;
                    fpos_next  = '0;
                end else begin
                    crc_next    = crc_upd;
                    remain_next = POS_W'(flag_len) + TRAILER_LEN;
                    fpos_next   = fpos_inc;
                    phase_next  = PH_BODY;
                end
            end
            default: begin
                if (remain_reg > TRAILER_LEN) begin
                    crc_next    = crc_upd;
                    remain_next = remain_reg - 1'b1;
                    fpos_next   = fpos_inc;
                end else if (remain_reg == TRAILER_LEN) begin
                    trail_next  = hold_byte;
                    remain_next = POS_W'(1);
                    fpos_next   = fpos_inc;
                end else begin
                    res_end     = 1'b1;
                    res_status  = ({hold_byte, trail_reg} == crc_reg) ?
                                  STATUS_GOOD : STATUS_BAD;
                    remain_next = '0;
                    phase_next  = PH_HUNT;
                    fpos_next   = '0;
                end
            end
        endcase
    end

    assign out_valid_next = hold_take ? res_valid : (out_valid_reg && !m_ready);

    // control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RESET;
            phase_reg     <= PH_HUNT;
            remain_reg    <= '0;
            crc_reg       <= '0;
            trail_reg     <= '0;
            fpos_reg      <= '0;
            lenlo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (hold_take) begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                crc_reg    <= crc_next;
                trail_reg  <= trail_next;
                fpos_reg   <= fpos_next;
                lenlo_reg  <= lenlo_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (hold_take && res_valid) begin
            out_byte_reg   <= hold_byte;
            out_pos_reg    <= res_pos;
            out_end_reg    <= res_end;
            out_status_reg <= res_status;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_byte    = out_byte_reg;
    assign m_byte_position = out_pos_reg;
    assign m_frame_end     = out_end_reg;
    assign m_frame_status  = out_status_reg;

    // outside the body no trailer count is left over
    a_remain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_BODY |-> remain_reg == '0)
        else $error("remaining count nonzero outside frame body");

    // inside the body the count stays within payload plus trailer
    a_remain_body: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> (remain_reg != '0) && (remain_reg <= REMAIN_MAX))
        else $error("remaining count out of range in frame body");

    // once sync is seen the next position is past the sync byte
    a_fpos_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HUNT |-> fpos_reg != '0)
        else $error("frame position zero inside a frame");

    // a dropped hunting byte leaves the result slot empty
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_take && phase_reg == PH_HUNT && hold_byte != SYNC_BYTE |=> !out_valid_reg)
        else $error("result produced for a byte outside a frame");

    // status is only set on the byte that ends a frame
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_end_reg |-> out_status_reg == STATUS_BUSY)
        else $error("status set on a byte that does not end the frame");

endmodule

// ===== sv/crc16_framed_packet_parser.sv =====
// ---------------------------------------------------------------------------
// crc16_framed_packet_parser
// Length-prefixed frame parser: hunts for the sync byte, reads the flag
// word, limits the payload length and checks the crc-16 trailer.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_rx_byte
//   m_        out        m_valid / m_ready    m_frame_byte, m_byte_position,
//                                             m_frame_end, m_frame_status
//   cfg_      in         cfg_wr_en            cfg_wr_data (payload limit)
//
// one item per cycle sustained while the result register does not stall;
// each byte passes through the input register, then through the crc and
// frame logic into the result register
// reset clears frame state and sets the payload limit to 1017
// a stalled result register holds the parser; the input register keeps
// at most one waiting item; if not taken, it holds s_ready low while full
// ---------------------------------------------------------------------------
module crc16_framed_packet_parser
    import cfpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_frame_byte,
    output logic [POS_W-1:0]    m_byte_position,
    output logic                m_frame_end,
    output logic [STATUS_W-1:0] m_frame_status
);

    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              hold_take;

    // input register
    cfpp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_take  (hold_take)
    );

    // parser and result register
    cfpp_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .hold_valid      (hold_valid),
        .hold_byte       (hold_byte),
        .hold_take       (hold_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_frame_end     (m_frame_end),
        .m_frame_status  (m_frame_status)
    );

endmodule

// ===== tb/tb_crc16_framed_packet_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc16_framed_packet_parser
// Self-checking bench for the length-prefixed frame parser. Frames with good
// and corrupted crc trailers, over-long length words, truncated frames and
// line noise are streamed in under random sender gaps and receiver stalls.
// Every echoed byte is compared against an in-bench model of the parser,
// across several payload limit settings including both extremes.
// ----------------------------------------------------------------------------
module tb_crc16_framed_packet_parser
    import cfpp_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF    = 8;
    localparam int MAX_REPORTS = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [1:0] {HUNT, FLAG_LO, FLAG_HI, BODY} parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [POS_W-1:0]    pos;
        logic                last;
        logic [STATUS_W-1:0] status;
    } byte_echo_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]    cfg_wr_data = LIMIT_RESET;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_rx_byte   = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [BYTE_W-1:0]   m_frame_byte;
    logic [POS_W-1:0]    m_byte_position;
    logic                m_frame_end;
    logic [STATUS_W-1:0] m_frame_status;

    // parser model state
    parse_phase_t        prs_phase   = HUNT;
    logic [POS_W-1:0]    body_left   = '0;
    logic [CRC_W-1:0]    frame_crc   = '0;
    logic [BYTE_W-1:0]   crc_low_rx  = '0;
    logic [POS_W-1:0]    next_pos    = '0;
    logic [1:0]          flag_len_lo = '0;
    logic [LEN_W-1:0]    limit_now   = LIMIT_RESET;

    logic [BYTE_W-1:0]   rx_stream[$];
    byte_echo_t          echo_pending[$];
    byte_echo_t          want;

    int unsigned         bytes_sent     = 0;
    int unsigned         bytes_taken    = 0;
    int unsigned         mismatch_cnt   = 0;
    int unsigned         cycle_cnt      = 0;
    int unsigned         gap_left       = 0;
    int unsigned         burst_left     = 0;
    int unsigned         sender_gap_max = 0;
    logic [15:0]         ready_pattern  = '1;
    logic [3:0]          ready_idx      = '0;

    crc16_framed_packet_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_frame_end     (m_frame_end),
        .m_frame_status  (m_frame_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // crc-16 xmodem, one data bit folded into the feedback per step
    function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = acc;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = c[CRC_W-1] ^ data[k];
            c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    // advance the parser model by one item, queue the echo it produces
    task automatic model_take(input logic [BYTE_W-1:0] b);
        byte_echo_t       e;
        logic             emit;
        logic [LEN_W-1:0] len;
        e.data   = b;
        e.pos    = next_pos;
        e.last   = 1'b0;
        e.status = STATUS_BUSY;
        emit     = 1'b1;
        case (prs_phase)
            HUNT: begin
                if (b == SYNC_BYTE) begin
                    frame_crc = crc16_next('0, b);
                    e.pos     = '0;
                    next_pos  = POS_W'(1);
                    prs_phase = FLAG_LO;
                end else begin
                    emit = 1'b0;
                end
            end
            FLAG_LO: begin
                flag_len_lo = b[7:6];
                frame_crc   = crc16_next(frame_crc, b);
                next_pos++;
                prs_phase   = FLAG_HI;
            end
            FLAG_HI: begin
                len = {b, flag_len_lo};
                if (len > limit_now) begin
                    // over-long frame is aborted on the second flag byte
                    e.last    = 1'b1;
                    e.status  = STATUS_LONG;
                    prs_phase = HUNT;
                    next_pos  = '0;
                end else begin
                    frame_crc = crc16_next(frame_crc, b);
                    body_left = POS_W'(len) + TRAILER_LEN;
                    next_pos++;
                    prs_phase = BODY;
                end
            end
            default: begin
                if (body_left > TRAILER_LEN) begin
                    frame_crc = crc16_next(frame_crc, b);
                    body_left--;
                    next_pos++;
                end else if (body_left == TRAILER_LEN) begin
                    crc_low_rx = b;
                    body_left  = POS_W'(1);
                    next_pos++;
                end else begin
                    e.last    = 1'b1;
                    e.status  = ({b, crc_low_rx} == frame_crc) ? STATUS_GOOD : STATUS_BAD;
                    body_left = '0;
                    prs_phase = HUNT;
                    next_pos  = '0;
                end
            end
        endcase
        if (emit) echo_pending = {echo_pending, e};
    endtask

    // build one frame with a correct trailer, optionally spoil or truncate it
    task automatic queue_frame(input logic [LEN_W-1:0] len, input bit spoil,
                               input bit sync_fill, input int unsigned keep);
        logic [BYTE_W-1:0] fr[$];
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] pb;
        int unsigned       hit;
        fr = {fr, SYNC_BYTE};
        fr = {fr, {len[1:0], 6'($urandom)}};
        fr = {fr, len[LEN_W-1:2]};
        for (int i = 0; i < len; i++) begin
            pb = (sync_fill || $urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom);
            fr = {fr, pb};
        end
        c = '0;
        foreach (fr[i]) c = crc16_next(c, fr[i]);
        fr = {fr, c[7:0]};
        fr = {fr, c[15:8]};
        if (spoil) begin
            hit     = fr.size() - 1 - $urandom_range(0, 1);
            fr[hit] = fr[hit] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (keep == 0 || keep > fr.size()) keep = fr.size();
        for (int i = 0; i < keep; i++) rx_stream = {rx_stream, fr[i]};
    endtask

    // mostly well-formed frames, some over-long, noise and cut-off frames
    task automatic random_traffic(input int unsigned budget);
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] junk;
        int unsigned       pick;
        int unsigned       top;
        int unsigned       target;
        target = rx_stream.size() + budget;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            top  = (limit_now < 12) ? limit_now : 12;
            len  = LEN_W'($urandom_range(0, top));
            if (limit_now <= 64 && $urandom_range(0, 9) == 0) len = limit_now;
            if (pick < 68) begin
                queue_frame(len, $urandom_range(0, 5) == 0, 1'b0, 0);
            end else if (pick < 80 && limit_now != LEN_MAX) begin
                if ($urandom_range(0, 1) == 0) begin
                    len = limit_now + 1'b1;
                end else begin
                    len = LEN_W'($urandom_range(limit_now + 1, LEN_MAX));
                end
                queue_frame(len, 1'b0, 1'b0, 3);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 4)) begin
                    do junk = 8'($urandom); while (junk == SYNC_BYTE);
                    rx_stream = {rx_stream, junk};
                end
            end else begin
                queue_frame(len, 1'b0, 1'b0, $urandom_range(3, len + 4));
            end
        end
    endtask

    // pick sender gaps and receiver stall pattern for the next phase
    task automatic shuffle_idling();
        sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        case ($urandom_range(0, 3))
            0:       ready_pattern = '1;
            1:       ready_pattern = 16'h8001;
            default: ready_pattern = 16'($urandom) | 16'h0001;
        endcase
    endtask

    // wait until every item is taken and every echo has come out
    task automatic drain();
        while (rx_stream.size() != 0 || bytes_taken != bytes_sent ||
               echo_pending.size() != 0)
            @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_now    = value;
        shuffle_idling();
        @(posedge aclk);
    endtask

    // sender: bursts of items with random gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || bytes_taken == bytes_sent) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
                s_rx_byte <= rx_stream.pop_front();
                s_valid   <= 1'b1;
                bytes_sent++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (sender_gap_max == 0) ? 0 : $urandom_range(1, sender_gap_max);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: ready follows a rotating stall pattern
    always @(negedge aclk) begin
        m_ready   <= ready_pattern[ready_idx];
        ready_idx <= ready_idx + 1'b1;
    end

    // check echoes against the model, then feed accepted items to it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (echo_pending.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("extra echo @%0d: byte %02h pos %0d end %0b st %0d",
                                 cycle_cnt, m_frame_byte, m_byte_position, m_frame_end,
                                 m_frame_status);
                end else begin
                    want = echo_pending.pop_front();
                    if (m_frame_byte !== want.data || m_byte_position !== want.pos ||
                        m_frame_end !== want.last || m_frame_status !== want.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("mismatch @%0d: want %02h pos %0d end %0b st %0d",
                                     cycle_cnt, want.data, want.pos, want.last,
                                     want.status);
                            $display("    got %02h pos %0d end %0b st %0d",
                                     m_frame_byte, m_byte_position, m_frame_end,
                                     m_frame_status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                model_take(s_rx_byte);
                bytes_taken++;
            end
        end
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        shuffle_idling();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: noise, empty frame, bad crc, over-long lengths, sync in payload
        rx_stream = {rx_stream, 8'h00};
        rx_stream = {rx_stream, 8'hFF};
        queue_frame('0, 1'b0, 1'b0, 0);
        queue_frame(LEN_W'(1), 1'b1, 1'b0, 0);
        queue_frame(LEN_MAX, 1'b0, 1'b0, 3);
        queue_frame(LIMIT_RESET + 1'b1, 1'b0, 1'b0, 3);
        queue_frame(LEN_W'(2), 1'b0, 1'b1, 0);
        random_traffic(30);

        // limit zero: only empty payloads pass
        write_limit('0);
        random_traffic(20);

        // no length is too long; one frame of the largest size
        write_limit(LEN_MAX);
        queue_frame(LEN_MAX, 1'b0, 1'b0, 0);
        random_traffic(10);

        // small limit so frames land right on the boundary
        write_limit(LEN_W'($urandom_range(1, 40)));
        random_traffic(20);

        write_limit(LEN_W'($urandom_range(0, LEN_MAX)));
        random_traffic(20);

        drain();
        if (mismatch_cnt == 0 && echo_pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cfpp_pkg.sv
sv/cfpp_in_reg.sv
sv/cfpp_core.sv
sv/crc16_framed_packet_parser.sv
tb/tb_crc16_framed_packet_parser.sv
